@@ rtl/swm_pkg.sv @@
`default_nettype none

package swm_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int MEDIAN_W    = 33;
  localparam int WS_W        = 7;
  localparam int WINDOW_MAX  = 64;
  localparam int WS_RESET    = 3;
  localparam int OFIFO_DEPTH = 4;

  // register map, byte address divided by four
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // one record as seen by a neighboring cell
  typedef struct packed {
    logic                        v;    // record holds a window sample
    logic                        g;    // record sorts above the incoming sample
    logic signed [SAMPLE_W-1:0]  val;
  } swm_link_t;

  // window length in effect for a register value: zero means one, capped at kmax
  function automatic int eff_k(input logic [WS_W-1:0] ws, input int kmax);
    int k;
    k = int'(ws);
    if (k == 0) k = 1;
    if (k > kmax) k = kmax;
    return k;
  endfunction

endpackage

`default_nettype wire

@@ rtl/swm_cell.sv @@
`default_nettype none

module swm_cell #(
  parameter int AGE_W = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        clear,
  input  wire logic                        full,
  input  wire logic signed [31:0]          sample,
  input  wire logic signed [31:0]          rem_val,
  input  wire logic [AGE_W-1:0]            rem_age,
  input  wire swm_pkg::swm_link_t          up_link,
  input  wire logic [AGE_W-1:0]            up_age,
  input  wire swm_pkg::swm_link_t          dn_link,
  input  wire logic [AGE_W-1:0]            dn_age,
  output swm_pkg::swm_link_t               cur_link,
  output logic [AGE_W-1:0]                 cur_age,
  output logic                             oldest,
  output swm_pkg::swm_link_t               rm_link,
  output logic [AGE_W-1:0]                 rm_age
);
  import swm_pkg::*;

  logic                 v_r, v_nxt;
  logic signed [31:0]   val_r, val_nxt;
  logic [AGE_W-1:0]     age_r, age_nxt;
  logic                 vis;
  logic                 ge;

  assign vis      = v_r & ~clear;
  assign cur_link = '{v: vis, g: (~vis | (val_r > sample)), val: val_r};
  assign cur_age  = age_r;
  assign oldest   = vis & (age_r == rem_age);

  // at or above the leaving record (equal values: older sits lower)
  assign ge = full & (~vis | (val_r > rem_val) | ((val_r == rem_val) & (age_r <= rem_age)));

  // window after removal: records above the leaving one step down
  assign rm_link = ge ? up_link : cur_link;
  assign rm_age  = ge ? up_age : age_r;

  // then insertion of the new sample
  always_comb begin
    if (!rm_link.g) begin
      v_nxt   = rm_link.v;
      val_nxt = rm_link.val;
      age_nxt = rm_age + AGE_W'(1);
    end else if (dn_link.g) begin
      v_nxt   = dn_link.v;
      val_nxt = dn_link.val;
      age_nxt = dn_age + AGE_W'(1);
    end else begin
      v_nxt   = 1'b1;
      val_nxt = sample;
      age_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/swm_out_fifo.sv @@
`default_nettype none

module swm_out_fifo #(
  parameter int DEPTH = swm_pkg::OFIFO_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [swm_pkg::MEDIAN_W-1:0] wr_data,
  output logic                            rd_valid,
  input  wire logic                       rd_ready,
  output logic [swm_pkg::MEDIAN_W-1:0]    rd_data,
  output logic [$clog2(DEPTH+1)-1:0]      count
);
  import swm_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [MEDIAN_W-1:0] mem_r [DEPTH];
  logic [PW-1:0]       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                rd_en;

  assign rd_valid = (cnt_r != '0);
  assign rd_en    = rd_valid & rd_ready;
  assign rd_data  = mem_r[rp_r];
  assign count    = cnt_r;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      wp_nxt = (int'(wp_r) == DEPTH-1) ? '0 : wp_r + PW'(1);
    end
    if (rd_en) begin
      rp_nxt = (int'(rp_r) == DEPTH-1) ? '0 : rp_r + PW'(1);
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sliding_window_median.sv @@
`default_nettype none

// Channel   Dir  Signals                      Contents
// in_       in   tvalid/tready/tdata/tuser    tdata[31:0] sample; tuser[0] new_sequence
// out_      out  tvalid/tready/tdata          tdata[32:0] median_doubled, [39:33] zero
// cfg_      in   APB psel/penable/pwrite/...  0x0 window_size (7 bits)
//
// One sample per clock while in_tready is high. The window is a row of WINDOW_MAX
// cells kept in sorted order; each accepted sample removes the oldest record (when
// full) and inserts the new one in the same cycle; each cell sees its two neighbors,
// the sample and the leaving value. A result passes median pick, add, output queue.
// Synchronous reset empties the window and loads window_size = 3; no clearing pass.
// in_tready drops only when the output queue plus the two stages in flight are full.

module sliding_window_median #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] sample
  input  wire logic [0:0]  in_tuser,   // [0] new_sequence
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [32:0] median_doubled
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import swm_pkg::*;

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;  // cell index / age
  localparam int KW = $clog2(WINDOW_MAX + 1);                     // window length
  localparam int FCW = $clog2(OFIFO_DEPTH + 1);

  // ---------------- configuration ----------------
  logic [WS_W-1:0] ws_r;
  logic [KW-1:0]   k_r, k_nxt;
  logic [AW-1:0]   ra_r, ia_r, ib_r;    // oldest age, lower and upper middle index
  logic [AW-1:0]   ra_nxt, ia_nxt, ib_nxt;
  logic            cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                & (cfg_paddr[2] == REG_WINDOW_SIZE);
  assign cfg_prdata = (cfg_paddr[2] == REG_WINDOW_SIZE) ? {{(32-WS_W){1'b0}}, ws_r} : '0;

  always_comb begin
    k_nxt  = KW'(eff_k(cfg_pwdata[WS_W-1:0], WINDOW_MAX));
    ra_nxt = AW'(k_nxt - KW'(1));
    ia_nxt = AW'((k_nxt - KW'(1)) >> 1);
    ib_nxt = AW'(k_nxt >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= WS_W'(WS_RESET);
      k_r  <= KW'(eff_k(WS_W'(WS_RESET), WINDOW_MAX));
      ra_r <= AW'(eff_k(WS_W'(WS_RESET), WINDOW_MAX) - 1);
      ia_r <= AW'((eff_k(WS_W'(WS_RESET), WINDOW_MAX) - 1) / 2);
      ib_r <= AW'(eff_k(WS_W'(WS_RESET), WINDOW_MAX) / 2);
    end else if (cfg_wr) begin
      ws_r <= cfg_pwdata[WS_W-1:0];
      k_r  <= k_nxt;
      ra_r <= ra_nxt;
      ia_r <= ia_nxt;
      ib_r <= ib_nxt;
    end
  end

  // ---------------- fill control ----------------
  logic [KW-1:0] fill_r, fill_nxt, fill_eff;
  logic          in_acc, full, produce, clear;
  logic          p1_r, p2_r;
  logic [FCW-1:0] fifo_cnt;

  // queue entries plus transactions still in the pick and add stages
  assign in_tready = ({1'b0, fifo_cnt} + (FCW+1)'(p1_r) + (FCW+1)'(p2_r))
                   < (FCW+1)'(OFIFO_DEPTH);
  assign in_acc   = in_tvalid & in_tready;
  assign fill_eff = in_tuser[0] ? '0 : fill_r;
  assign clear    = (fill_eff == '0);      // empty window: every cell reads as vacant
  assign full     = (fill_eff >= k_r);
  assign produce  = full | ((fill_eff + KW'(1)) == k_r);
  assign fill_nxt = full ? fill_eff : fill_eff + KW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cfg_wr) begin
      fill_r <= '0;
    end else if (in_acc) begin
      fill_r <= fill_nxt;
    end
  end

  // ---------------- sorted cell row ----------------
  swm_link_t              c_link  [WINDOW_MAX];
  logic [AW-1:0]          c_age   [WINDOW_MAX];
  swm_link_t              r_link  [WINDOW_MAX];
  logic [AW-1:0]          r_age   [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]  old_hit;
  logic signed [31:0]     rem_val;
  swm_link_t              top_link, bot_link;

  assign top_link = '{v: 1'b0, g: 1'b1, val: '0};   // vacant beyond the last cell
  assign bot_link = '{v: 1'b0, g: 1'b0, val: '0};   // nothing below cell 0

  // value of the sample about to leave: at most one cell matches
  always_comb begin
    rem_val = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      rem_val = rem_val | (old_hit[i] ? c_link[i].val : '0);
    end
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_link_t     up_l, dn_l;
    logic [AW-1:0] up_a, dn_a;

    if (i == WINDOW_MAX - 1) begin : g_top
      assign up_l = top_link;
      assign up_a = '0;
    end else begin : g_mid
      assign up_l = c_link[i+1];
      assign up_a = c_age[i+1];
    end

    if (i == 0) begin : g_bot
      assign dn_l = bot_link;
      assign dn_a = '0;
    end else begin : g_up
      assign dn_l = r_link[i-1];
      assign dn_a = r_age[i-1];
    end

    swm_cell #(.AGE_W(AW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (in_acc),
      .clear    (clear),
      .full     (full),
      .sample   (in_tdata),
      .rem_val  (rem_val),
      .rem_age  (ra_r),
      .up_link  (up_l),
      .up_age   (up_a),
      .dn_link  (dn_l),
      .dn_age   (dn_a),
      .cur_link (c_link[i]),
      .cur_age  (c_age[i]),
      .oldest   (old_hit[i]),
      .rm_link  (r_link[i]),
      .rm_age   (r_age[i])
    );
  end

  // ---------------- median pick and add ----------------
  logic signed [31:0] ma_r, mb_r;
  logic [MEDIAN_W-1:0] med_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= 1'b0;
      p2_r <= 1'b0;
    end else begin
      p1_r <= in_acc & produce;
      p2_r <= p1_r;
    end
  end

  // cells hold the updated window during the cycle after the transaction
  always_ff @(posedge clk) begin
    if (p1_r) begin
      ma_r <= c_link[ia_r].val;
      mb_r <= c_link[ib_r].val;
    end
  end

  assign med_sum = MEDIAN_W'({ma_r[31], ma_r} + {mb_r[31], mb_r});

  // ---------------- output queue ----------------
  logic [MEDIAN_W-1:0] out_med;

  swm_out_fifo #(.DEPTH(OFIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (p2_r),
    .wr_data  (med_sum),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (out_med),
    .count    (fifo_cnt)
  );

  assign out_tdata = {{(40-MEDIAN_W){1'b0}}, out_med};

endmodule

`default_nettype wire
